[rtl/core/pad_change_event_scanner_core_macros.svh]
// Assertion macros for the pad change event scanner.
// Used by the datapath; needs a clk and rst in scope.
`ifndef PAD_CHANGE_EVENT_SCANNER_CORE_MACROS_SVH
`define PAD_CHANGE_EVENT_SCANNER_CORE_MACROS_SVH

// Checked at every edge, including while reset is high.
`define PCES_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define PCES_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[rtl/core/pces_pkg.sv]
// Shared constants and types for the pad change event scanner.
// Used by the controller, the datapath and the top level; no dependencies.
package pces_pkg;

  localparam int NUM_SEATS   = 4;
  localparam int NUM_BUTTONS = 12;
  localparam int NUM_AXES    = 6;
  localparam int START_BIT   = 5;
  localparam int DIV_STEPS   = 16;

  localparam logic [15:0] AXIS_FULL   = 16'd32767;
  localparam logic [7:0]  STICK_TOP   = 8'd127;
  localparam logic [7:0]  TRIGGER_TOP = 8'd255;

  localparam logic [6:0] MAIN_DZ_RESET = 7'd12;
  localparam logic [6:0] SUB_DZ_RESET  = 7'd16;
  localparam logic [7:0] TRIG_DZ_RESET = 8'd20;

  // Scan slots: buttons first, then axes, then the join check.
  localparam logic [4:0] SLOT_FIRST_AXIS = 5'd12;
  localparam logic [4:0] SLOT_JOIN       = 5'd18;
  localparam logic [2:0] LAST_AXIS       = 3'd5;

  localparam logic [1:0] REG_MAIN_DZ = 2'd0;
  localparam logic [1:0] REG_SUB_DZ  = 2'd1;
  localparam logic [1:0] REG_TRIG_DZ = 2'd2;

  localparam logic [1:0] KIND_BUTTON = 2'd0;
  localparam logic [1:0] KIND_AXIS   = 2'd1;
  localparam logic [1:0] KIND_JOIN   = 2'd2;

  typedef struct packed {
    logic       load;
    logic       prep;
    logic       step;
    logic       store;
    logic       scan;
    logic       flush;
    logic [2:0] axis;
    logic [4:0] slot;
  } cmd_t;

  typedef struct packed {
    logic go;
    logic flush_done;
  } sts_t;

endpackage

[rtl/core/pces_ctrl.sv]
// Sequencer of the pad change event scanner: axis filtering, then the scan.
// Depends on pces_pkg.
module pces_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pces_pkg::sts_t sts,
  output pces_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_DIV, ST_STORE, ST_SCAN, ST_FLUSH
  } state_t;

  state_t     state;
  logic [2:0] axis;
  logic [3:0] bitcnt;
  logic [4:0] slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      axis   <= '0;
      bitcnt <= '0;
      slot   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_PREP;
            axis  <= '0;
          end
        end
        ST_PREP: begin
          state  <= ST_DIV;
          bitcnt <= '0;
        end
        ST_DIV: begin
          bitcnt <= bitcnt + 4'd1;
          if (bitcnt == 4'(pces_pkg::DIV_STEPS - 1)) state <= ST_STORE;
        end
        ST_STORE: begin
          if (axis == pces_pkg::LAST_AXIS) begin
            state <= ST_SCAN;
            slot  <= '0;
          end else begin
            axis  <= axis + 3'd1;
            state <= ST_PREP;
          end
        end
        ST_SCAN: begin
          if (sts.go) begin
            if (slot == pces_pkg::SLOT_JOIN) state <= ST_FLUSH;
            else slot <= slot + 5'd1;
          end
        end
        ST_FLUSH: begin
          if (sts.flush_done) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.load  = (state == ST_IDLE) && in_valid;
    cmd.prep  = (state == ST_PREP);
    cmd.step  = (state == ST_DIV);
    cmd.store = (state == ST_STORE);
    cmd.scan  = (state == ST_SCAN);
    cmd.flush = (state == ST_FLUSH);
    cmd.axis  = axis;
    cmd.slot  = slot;
  end

endmodule

[rtl/core/pces_dp.sv]
// Datapath of the pad change event scanner: poll registers, axis filter with
// a restoring divider, per-seat reported state and the output stage.
// Depends on pces_pkg and pad_change_event_scanner_core_macros.svh.
`include "pad_change_event_scanner_core_macros.svh"

module pces_dp (
  input  logic              clk,
  input  logic              rst,
  input  pces_pkg::cmd_t    cmd,
  output pces_pkg::sts_t    sts,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [1:0]        seat,
  input  logic              pad_present,
  input  logic [11:0]       button_bits,
  input  logic [7:0]        main_x,
  input  logic [7:0]        main_y,
  input  logic [7:0]        sub_x,
  input  logic [7:0]        sub_y,
  input  logic [7:0]        trigger_left,
  input  logic [7:0]        trigger_right,
  input  logic              session_active,
  input  logic              seat_taken,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        event_kind,
  output logic [1:0]        event_seat,
  output logic [3:0]        event_index,
  output logic signed [15:0] event_value,
  output logic              last_event
);

  localparam int AX_DEPTH = pces_pkg::NUM_SEATS * pces_pkg::NUM_AXES;

  logic [6:0] main_dz;
  logic [6:0] sub_dz;
  logic [7:0] trig_dz;

  logic [1:0]  p_seat;
  logic        p_present;
  logic        p_seat_ok;
  logic [11:0] p_buttons;
  logic [7:0]  p_raw [pces_pkg::NUM_AXES];
  logic        p_session;
  logic        p_taken;

  // A seat that is not connected always holds zero reported state, so an
  // absent pad only reports releases when the seat was connected before.
  logic [11:0] rep_btn    [pces_pkg::NUM_SEATS];
  logic [15:0] rep_axes   [AX_DEPTH];
  logic        start_held [pces_pkg::NUM_SEATS];
  logic [15:0] axis_new   [pces_pkg::NUM_AXES];

  logic [7:0]  rem;
  logic [15:0] num;
  logic [15:0] quo;
  logic [7:0]  span_r;
  logic        zero_f;
  logic        full_f;
  logic        neg_f;

  logic        pend_valid;
  logic [1:0]  pend_kind;
  logic [3:0]  pend_index;
  logic [15:0] pend_value;

  // Axis set-up for the axis the controller points at.
  logic [7:0]  raw8;
  logic [7:0]  dz8;
  logic        is_trig;
  logic [7:0]  mag8;
  logic [7:0]  span8;
  logic [7:0]  amt;
  logic [22:0] numer;
  logic        zero_c;
  logic        full_c;

  always_comb begin
    raw8    = p_raw[cmd.axis];
    is_trig = (cmd.axis >= 3'd4);
    if (cmd.axis < 3'd2)      dz8 = {1'b0, main_dz};
    else if (cmd.axis < 3'd4) dz8 = {1'b0, sub_dz};
    else                      dz8 = trig_dz;
    if (is_trig) begin
      mag8   = raw8;
      span8  = pces_pkg::TRIGGER_TOP - dz8;
      zero_c = (mag8 < dz8) || (dz8 == pces_pkg::TRIGGER_TOP);
      full_c = 1'b0;
    end else begin
      mag8   = raw8[7] ? 8'(-raw8) : raw8;
      span8  = pces_pkg::STICK_TOP - dz8;
      zero_c = (mag8 <= dz8);
      full_c = (dz8 == pces_pkg::STICK_TOP);
    end
    zero_c = zero_c || !p_present;
    amt    = mag8 - dz8;
    numer  = ({15'd0, amt} << 15) - {15'd0, amt};
  end

  // One restoring division step.
  logic [8:0] trial;
  logic       ge;
  assign trial = {rem, num[15]};
  assign ge    = (trial >= {1'b0, span_r});

  logic [15:0] mag_q;
  logic [15:0] mag_final;
  assign mag_q     = (quo > pces_pkg::AXIS_FULL) ? pces_pkg::AXIS_FULL : quo;
  assign mag_final = zero_f ? 16'd0 : (full_f ? pces_pkg::AXIS_FULL : mag_q);

  // Scan slot evaluation.
  logic [3:0]  bidx;
  logic [2:0]  aslot;
  logic [4:0]  aidx;
  logic        newbit;
  logic        start_now;
  logic        hit;
  logic [1:0]  hit_kind;
  logic [3:0]  hit_index;
  logic [15:0] hit_value;
  logic        out_free;

  always_comb begin
    bidx      = cmd.slot[3:0];
    aslot     = 3'(cmd.slot - pces_pkg::SLOT_FIRST_AXIS);
    aidx      = 5'(p_seat) * 5'(pces_pkg::NUM_AXES) + 5'(aslot);
    newbit    = p_present & p_buttons[bidx];
    start_now = p_buttons[pces_pkg::START_BIT];
    hit       = 1'b0;
    hit_kind  = pces_pkg::KIND_BUTTON;
    hit_index = '0;
    hit_value = '0;
    if (cmd.slot < pces_pkg::SLOT_FIRST_AXIS) begin
      hit       = (rep_btn[p_seat][bidx] != newbit);
      hit_index = bidx;
      hit_value = {15'd0, newbit};
    end else if (cmd.slot < pces_pkg::SLOT_JOIN) begin
      hit       = (rep_axes[aidx] != axis_new[aslot]);
      hit_kind  = pces_pkg::KIND_AXIS;
      hit_index = {1'b0, aslot};
      hit_value = axis_new[aslot];
    end else begin
      hit      = p_present && (p_seat != 2'd0) && start_now && !start_held[p_seat]
                 && p_session && !p_taken;
      hit_kind = pces_pkg::KIND_JOIN;
    end
    hit = hit && p_seat_ok;
  end

  assign out_free       = !out_valid || out_ready;
  assign sts.go         = !hit || !pend_valid || out_free;
  assign sts.flush_done = !pend_valid || out_free;

  logic commit;
  logic push_scan;
  logic push_flush;
  assign commit     = cmd.scan && sts.go && p_seat_ok;
  assign push_scan  = cmd.scan && sts.go && hit && pend_valid;
  assign push_flush = cmd.flush && pend_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_dz    <= pces_pkg::MAIN_DZ_RESET;
      sub_dz     <= pces_pkg::SUB_DZ_RESET;
      trig_dz    <= pces_pkg::TRIG_DZ_RESET;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int s = 0; s < pces_pkg::NUM_SEATS; s++) begin
        rep_btn[s]    <= '0;
        start_held[s] <= 1'b0;
      end
      for (int k = 0; k < AX_DEPTH; k++) rep_axes[k] <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          pces_pkg::REG_MAIN_DZ: main_dz <= cfg_data[6:0];
          pces_pkg::REG_SUB_DZ:  sub_dz  <= cfg_data[6:0];
          pces_pkg::REG_TRIG_DZ: trig_dz <= cfg_data;
          default: ;
        endcase
      end

      if (commit) begin
        if (cmd.slot < pces_pkg::SLOT_FIRST_AXIS) begin
          rep_btn[p_seat][bidx] <= newbit;
        end else if (cmd.slot < pces_pkg::SLOT_JOIN) begin
          rep_axes[aidx] <= axis_new[aslot];
        end else if (p_present && (p_seat != 2'd0)) begin
          start_held[p_seat] <= start_now;
        end
      end

      if (out_valid && out_ready) out_valid <= 1'b0;
      if (push_scan || push_flush) out_valid <= 1'b1;

      if (cmd.scan && sts.go && hit) pend_valid <= 1'b1;
      else if (push_flush) pend_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_seat    <= seat;
      p_seat_ok <= (4'(seat) < 4'(pces_pkg::NUM_SEATS));
      p_present <= pad_present;
      p_buttons <= button_bits;
      p_raw[0]  <= main_x;
      p_raw[1]  <= main_y;
      p_raw[2]  <= sub_x;
      p_raw[3]  <= sub_y;
      p_raw[4]  <= trigger_left;
      p_raw[5]  <= trigger_right;
      p_session <= session_active;
      p_taken   <= seat_taken;
    end
    if (cmd.prep) begin
      rem    <= {1'b0, numer[22:16]};
      num    <= numer[15:0];
      quo    <= '0;
      span_r <= span8;
      zero_f <= zero_c;
      full_f <= full_c && !zero_c;
      // Y axes are reported with up negative; triggers carry no sign.
      neg_f  <= !is_trig && (raw8[7] ^ cmd.axis[0]);
    end
    if (cmd.step) begin
      rem <= ge ? 8'(trial - {1'b0, span_r}) : trial[7:0];
      num <= {num[14:0], 1'b0};
      quo <= {quo[14:0], ge};
    end
    if (cmd.store) begin
      axis_new[cmd.axis] <= neg_f ? 16'(-mag_final) : mag_final;
    end
    if (cmd.scan && sts.go && hit) begin
      pend_kind  <= hit_kind;
      pend_index <= hit_index;
      pend_value <= hit_value;
    end
    if (push_scan || push_flush) begin
      event_kind  <= pend_kind;
      event_seat  <= p_seat;
      event_index <= pend_index;
      event_value <= pend_value;
      last_event  <= push_flush;
    end
  end

  `PCES_CHECK(a_flush_empties, (cmd.flush && sts.flush_done) |=> !pend_valid, "word left pending after flush")
  `PCES_CHECK(a_join_is_last, (out_valid && event_kind == pces_pkg::KIND_JOIN) |-> last_event, "join request not last word")
  `PCES_CHECK(a_div_span, cmd.store |-> (zero_f || full_f || span_r != 8'd0), "division by zero span")
  `PCES_ALWAYS(a_reset_idle, rst |=> !pend_valid && !out_valid, "output stage busy after reset")

endmodule

[rtl/core/pad_change_event_scanner_core.sv]
// Pad change event scanner: one poll in, zero to nineteen change words out.
// Axis filtering runs first (six axes in turn through one 16-step restoring
// divider), then the 19 scan slots are walked in order plus a flush, stalling
// whenever a word is waiting on a busy output.
// A new poll is taken only after the previous one has been fully scanned.
// Reset (rst, synchronous) clears all seat state and loads the dead zone defaults.
module pad_change_event_scanner_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         seat,
  input  logic               pad_present,
  input  logic [11:0]        button_bits,
  input  logic signed [7:0]  main_x,
  input  logic signed [7:0]  main_y,
  input  logic signed [7:0]  sub_x,
  input  logic signed [7:0]  sub_y,
  input  logic [7:0]         trigger_left,
  input  logic [7:0]         trigger_right,
  input  logic               session_active,
  input  logic               seat_taken,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         event_kind,
  output logic [1:0]         event_seat,
  output logic [3:0]         event_index,
  output logic signed [15:0] event_value,
  output logic               last_event
);

  pces_pkg::cmd_t cmd;
  pces_pkg::sts_t sts;

  pces_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pces_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .seat           (seat),
    .pad_present    (pad_present),
    .button_bits    (button_bits),
    .main_x         (main_x),
    .main_y         (main_y),
    .sub_x          (sub_x),
    .sub_y          (sub_y),
    .trigger_left   (trigger_left),
    .trigger_right  (trigger_right),
    .session_active (session_active),
    .seat_taken     (seat_taken),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .event_seat     (event_seat),
    .event_index    (event_index),
    .event_value    (event_value),
    .last_event     (last_event)
  );

endmodule

[sim/pad_change_event_scanner_core_tb.sv]
// Self-checking bench for the pad change event scanner core.
// Walks a directed table and then random polls, and predicts every change word.
// Depends on pces_pkg and pad_change_event_scanner_core.
module pad_change_event_scanner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]        seat;
    logic              present;
    logic [11:0]       buttons;
    logic signed [7:0] mx, my, sx, sy;
    logic [7:0]        tl, tr;
    logic              active, taken;
  } poll_t;

  typedef struct {
    logic [1:0]         kind;
    logic [1:0]         seat;
    logic [3:0]         idx;
    logic signed [15:0] val;
    logic               last;
  } ev_t;

  typedef struct {
    poll_t p;
    int    ntyped;
    ev_t   e0, e1;
  } row_t;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 200;
  localparam int HOLD_OFF   = 3000;

  logic clk, rst;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] seat;
  logic pad_present;
  logic [11:0] button_bits;
  logic signed [7:0] main_x, main_y, sub_x, sub_y;
  logic [7:0] trigger_left, trigger_right;
  logic session_active, seat_taken;
  logic out_valid, out_ready;
  logic [1:0] event_kind, event_seat;
  logic [3:0] event_index;
  logic signed [15:0] event_value;
  logic last_event;

  pad_change_event_scanner_core uut (.*);

  // Predictor state
  int          dz_main, dz_sub, dz_trig;
  logic        conn[pces_pkg::NUM_SEATS];
  logic [11:0] held[pces_pkg::NUM_SEATS];
  int          axes_seen[pces_pkg::NUM_SEATS][pces_pkg::NUM_AXES];
  logic        start_held[pces_pkg::NUM_SEATS];
  ev_t         pending_events[$];
  ev_t         scratch[$];
  poll_t       prev_poll[pces_pkg::NUM_SEATS];

  int errors = 0;
  int words_seen = 0;
  int idle_cycles = 0;
  int hold = 0;
  bit pressure_done = 0;
  row_t dir_rows[16];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic poll_t mk(logic [1:0] s, logic pr, logic [11:0] b, int mx, int my,
                               int sx, int sy, int tl, int tr, logic act, logic tak);
    poll_t p;
    p.seat = s; p.present = pr; p.buttons = b;
    p.mx = 8'(mx); p.my = 8'(my); p.sx = 8'(sx); p.sy = 8'(sy);
    p.tl = 8'(tl); p.tr = 8'(tr); p.active = act; p.taken = tak;
    return p;
  endfunction

  function automatic ev_t ev(logic [1:0] k, logic [1:0] s, int i, int v, logic l);
    ev_t e;
    e.kind = k; e.seat = s; e.idx = 4'(i); e.val = 16'(v); e.last = l;
    return e;
  endfunction

  function automatic int stick_scale(int raw, int dz);
    int mag, span;
    mag = raw < 0 ? -raw : raw;
    span = 127 - dz;
    if (mag <= dz) return 0;
    if (span <= 0) begin
      mag = 32767;
    end else begin
      mag = (mag - dz) * 32767 / span;
      if (mag > 32767) mag = 32767;
    end
    return raw < 0 ? -mag : mag;
  endfunction

  function automatic int trigger_scale(int raw, int dz);
    int span;
    span = 255 - dz;
    if (raw < dz || span <= 0) return 0;
    return (raw - dz) * 32767 / span;
  endfunction

  // Works out the change words for one poll into scratch and updates the seat state.
  task automatic scan_poll(poll_t p);
    int s;
    int ax[pces_pkg::NUM_AXES];
    logic [11:0] b;
    s = p.seat;
    scratch.delete();
    if (!p.present) begin
      if (!conn[s]) return;
      b = '0;
      foreach (ax[i]) ax[i] = 0;
      conn[s] = 0;
    end else begin
      conn[s] = 1;
      b = p.buttons;
      ax[0] = stick_scale(int'(p.mx), dz_main);
      ax[1] = -stick_scale(int'(p.my), dz_main);
      ax[2] = stick_scale(int'(p.sx), dz_sub);
      ax[3] = -stick_scale(int'(p.sy), dz_sub);
      ax[4] = trigger_scale(int'(p.tl), dz_trig);
      ax[5] = trigger_scale(int'(p.tr), dz_trig);
    end
    for (int i = 0; i < pces_pkg::NUM_BUTTONS; i++)
      if (held[s][i] != b[i]) begin
        held[s][i] = b[i];
        scratch.push_back(ev(pces_pkg::KIND_BUTTON, 2'(s), i, int'(b[i]), 1'b0));
      end
    for (int i = 0; i < pces_pkg::NUM_AXES; i++)
      if (axes_seen[s][i] != ax[i]) begin
        axes_seen[s][i] = ax[i];
        scratch.push_back(ev(pces_pkg::KIND_AXIS, 2'(s), i, ax[i], 1'b0));
      end
    // Seat 0 never asks to join; a disconnect leaves the start history alone.
    if (p.present && s != 0) begin
      if (!b[pces_pkg::START_BIT]) begin
        start_held[s] = 0;
      end else if (!start_held[s]) begin
        start_held[s] = 1;
        if (p.active && !p.taken)
          scratch.push_back(ev(pces_pkg::KIND_JOIN, 2'(s), 0, 0, 1'b0));
      end
    end
    if (scratch.size() > 0) scratch[scratch.size() - 1].last = 1;
  endtask

  task automatic send_poll(poll_t p, int ntyped, ev_t e0, ev_t e1);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 :
          ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    seat <= p.seat; pad_present <= p.present; button_bits <= p.buttons;
    main_x <= p.mx; main_y <= p.my; sub_x <= p.sx; sub_y <= p.sy;
    trigger_left <= p.tl; trigger_right <= p.tr;
    session_active <= p.active; seat_taken <= p.taken;
    do @(posedge clk); while (!in_ready);
    scan_poll(p);
    if (ntyped < 0) begin
      foreach (scratch[i]) pending_events.push_back(scratch[i]);
    end else begin
      if (ntyped > 0) pending_events.push_back(e0);
      if (ntyped > 1) pending_events.push_back(e1);
    end
    prev_poll[p.seat] = p;
  endtask

  // Waits for the last word, then for any poll with nothing to report to finish.
  task automatic drain();
    in_valid <= 0;
    while (pending_events.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int v);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= 8'(v);
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
    if (idx == pces_pkg::REG_MAIN_DZ) dz_main = v & 8'h7f;
    else if (idx == pces_pkg::REG_SUB_DZ) dz_sub = v & 8'h7f;
    else if (idx == pces_pkg::REG_TRIG_DZ) dz_trig = v & 8'hff;
  endtask

  function automatic logic [7:0] rand_axis();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(0, 40) - 20);
      2: return 8'd0;
      default: return ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7f;
    endcase
  endfunction

  // Mostly a perturbed copy of the seat's last poll, so that only some fields change.
  function automatic poll_t rand_poll();
    poll_t p;
    int s;
    s = $urandom_range(0, pces_pkg::NUM_SEATS - 1);
    p = prev_poll[s];
    p.seat = 2'(s);
    p.present = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 1) != 0) p.buttons = 12'($urandom_range(0, 4095));
    else p.buttons = p.buttons ^ (12'd1 << $urandom_range(0, 11));
    if ($urandom_range(0, 2) == 0) p.mx = rand_axis();
    if ($urandom_range(0, 2) == 0) p.my = rand_axis();
    if ($urandom_range(0, 2) == 0) p.sx = rand_axis();
    if ($urandom_range(0, 2) == 0) p.sy = rand_axis();
    if ($urandom_range(0, 2) == 0) p.tl = rand_axis();
    if ($urandom_range(0, 2) == 0) p.tr = rand_axis();
    p.active = $urandom_range(0, 3) != 0;
    p.taken = $urandom_range(0, 2) == 0;
    return p;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    ev_t e;
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (pending_events.size() == 0) begin
        report("unexpected word, kind", event_kind, -1);
      end else begin
        e = pending_events.pop_front();
        if (event_kind !== e.kind) report("event_kind", event_kind, e.kind);
        if (event_seat !== e.seat) report("event_seat", event_seat, e.seat);
        if (event_index !== e.idx) report("event_index", event_index, e.idx);
        if (event_value !== e.val) report("event_value", event_value, e.val);
        if (last_event !== e.last) report("last_event", last_event, e.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: short random stalls, the odd long one, and one long hold-off.
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (!pressure_done && words_seen >= 40) begin
        pressure_done = 1;
        hold = HOLD_OFF;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else if ($urandom_range(0, 3) == 0) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  initial begin
    rst = 1; cfg_write = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; seat = '0; pad_present = 0; button_bits = '0;
    main_x = '0; main_y = '0; sub_x = '0; sub_y = '0;
    trigger_left = '0; trigger_right = '0; session_active = 0; seat_taken = 0;
    dz_main = pces_pkg::MAIN_DZ_RESET;
    dz_sub = pces_pkg::SUB_DZ_RESET;
    dz_trig = pces_pkg::TRIG_DZ_RESET;
    for (int s = 0; s < pces_pkg::NUM_SEATS; s++) begin
      conn[s] = 0; held[s] = '0; start_held[s] = 0;
      for (int a = 0; a < pces_pkg::NUM_AXES; a++) axes_seen[s][a] = 0;
      prev_poll[s] = mk(2'(s), 1, '0, 0, 0, 0, 0, 0, 0, 0, 0);
    end

    dir_rows[0]  = '{mk(3, 0, 12'h000, 0, 0, 0, 0, 0, 0, 1, 0), 0, ev(0, 0, 0, 0, 0),
                     ev(0, 0, 0, 0, 0)};
    dir_rows[1]  = '{mk(1, 1, 12'h020, 0, 0, 0, 0, 0, 0, 1, 0), 2,
                     ev(pces_pkg::KIND_BUTTON, 1, 5, 1, 0), ev(pces_pkg::KIND_JOIN, 1, 0, 0, 1)};
    dir_rows[2]  = '{mk(1, 1, 12'h020, 0, 0, 0, 0, 0, 0, 1, 0), 0, ev(0, 0, 0, 0, 0),
                     ev(0, 0, 0, 0, 0)};
    dir_rows[3]  = '{mk(1, 1, 12'h000, 0, 0, 0, 0, 0, 0, 1, 0), 1,
                     ev(pces_pkg::KIND_BUTTON, 1, 5, 0, 1), ev(0, 0, 0, 0, 0)};
    dir_rows[4]  = '{mk(1, 1, 12'h020, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     ev(pces_pkg::KIND_BUTTON, 1, 5, 1, 1), ev(0, 0, 0, 0, 0)};
    dir_rows[5]  = '{mk(1, 1, 12'h000, 0, 0, 0, 0, 0, 0, 1, 1), -1, ev(0, 0, 0, 0, 0),
                     ev(0, 0, 0, 0, 0)};
    dir_rows[6]  = '{mk(1, 1, 12'h020, 0, 0, 0, 0, 0, 0, 1, 1), -1, ev(0, 0, 0, 0, 0),
                     ev(0, 0, 0, 0, 0)};
    dir_rows[7]  = '{mk(0, 1, 12'h020, 0, 0, 0, 0, 0, 0, 1, 0), 1,
                     ev(pces_pkg::KIND_BUTTON, 0, 5, 1, 1), ev(0, 0, 0, 0, 0)};
    dir_rows[8]  = '{mk(2, 1, 12'hfff, 127, -128, -128, 127, 255, 255, 1, 0), -1,
                     ev(0, 0, 0, 0, 0), ev(0, 0, 0, 0, 0)};
    dir_rows[9]  = '{mk(2, 1, 12'h000, -128, 127, 127, -128, 0, 0, 1, 0), -1,
                     ev(0, 0, 0, 0, 0), ev(0, 0, 0, 0, 0)};
    dir_rows[10] = '{mk(2, 1, 12'h001, 12, 13, -16, -17, 20, 21, 1, 0), -1,
                     ev(0, 0, 0, 0, 0), ev(0, 0, 0, 0, 0)};
    dir_rows[11] = '{mk(2, 0, 12'hfff, 50, 50, 50, 50, 99, 99, 1, 0), -1,
                     ev(0, 0, 0, 0, 0), ev(0, 0, 0, 0, 0)};
    dir_rows[12] = '{mk(2, 0, 12'h000, 0, 0, 0, 0, 0, 0, 1, 0), 0, ev(0, 0, 0, 0, 0),
                     ev(0, 0, 0, 0, 0)};
    dir_rows[13] = '{mk(3, 1, 12'haaa, -1, 1, 40, -40, 19, 200, 1, 0), -1,
                     ev(0, 0, 0, 0, 0), ev(0, 0, 0, 0, 0)};
    dir_rows[14] = '{mk(3, 0, 12'h555, 0, 0, 0, 0, 0, 0, 1, 0), -1, ev(0, 0, 0, 0, 0),
                     ev(0, 0, 0, 0, 0)};
    // Start history survives the disconnect, so no second join here.
    dir_rows[15] = '{mk(3, 1, 12'haaa, 0, 0, 0, 0, 0, 0, 1, 0), -1, ev(0, 0, 0, 0, 0),
                     ev(0, 0, 0, 0, 0)};

    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (dir_rows[i]) send_poll(dir_rows[i].p, dir_rows[i].ntyped, dir_rows[i].e0,
                                    dir_rows[i].e1);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(pces_pkg::REG_MAIN_DZ, 0); write_reg(pces_pkg::REG_SUB_DZ, 0);
          write_reg(pces_pkg::REG_TRIG_DZ, 0);
        end
        1: begin
          // Zero-width spans: sticks read zero but saturate at -128, triggers always read zero.
          write_reg(pces_pkg::REG_MAIN_DZ, 127); write_reg(pces_pkg::REG_SUB_DZ, 127);
          write_reg(pces_pkg::REG_TRIG_DZ, 255);
        end
        2: begin
          write_reg(pces_pkg::REG_MAIN_DZ, 126); write_reg(pces_pkg::REG_SUB_DZ, 126);
          write_reg(pces_pkg::REG_TRIG_DZ, 254);
        end
        default: begin
          write_reg(pces_pkg::REG_MAIN_DZ, $urandom_range(0, 126));
          write_reg(pces_pkg::REG_SUB_DZ, $urandom_range(0, 126));
          write_reg(pces_pkg::REG_TRIG_DZ, $urandom_range(0, 254));
        end
      endcase
      repeat (54) send_poll(rand_poll(), -1, ev(0, 0, 0, 0, 0), ev(0, 0, 0, 0, 0));
    end

    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
